[hw/rtl/multi_channel_alarm_debouncer_top_defines.svh]
// assertion helpers for the alarm debouncer
// both sample on the rising edge of clk and stay quiet while rst is high
`ifndef MULTI_CHANNEL_ALARM_DEBOUNCER_TOP_DEFINES_SVH
`define MULTI_CHANNEL_ALARM_DEBOUNCER_TOP_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define MCAD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MCAD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/mcad_pkg.sv]
// ----------------------------------------------------------------------------
// mcad_pkg
// shared types, codes and defaults of the multi-channel alarm debouncer
// ----------------------------------------------------------------------------
package mcad_pkg;

  localparam int DEF_NUM_CHANNELS = 16;
  localparam int DEF_COUNT_BITS   = 16;
  localparam int MAX_RESULTS      = 16;

  localparam int CH_W  = 4;
  localparam int LVL_W = 2;
  localparam int DLY_W = 16;

  // request codes
  localparam logic REQ_REPORT = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  localparam logic [LVL_W-1:0] LVL_UNKNOWN = 2'd0;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_FIRST   = 2'd1,
    EV_TRIGGER = 2'd2,
    EV_RECOVER = 2'd3
  } event_kind_t;

  typedef struct packed {
    logic             req_type;
    logic [CH_W-1:0]  channel;
    logic [LVL_W-1:0] level;
    logic             status;
    logic [DLY_W-1:0] debounce_ticks;
  } req_item_t;

  typedef struct packed {
    logic [CH_W-1:0]  out_channel;
    logic [LVL_W-1:0] out_level;
    logic             out_status;
    event_kind_t      event_kind;
    logic             last;
  } rsp_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REPORT,
    ST_WALK,
    ST_FLUSH
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic rpt_eval;
    logic walk_eval;
    logic flush;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_tick;
    logic stall;
    logic walk_end;
    logic held_valid;
    logic out_free;
  } dp_status_t;

endpackage

[hw/rtl/mcad_req_if.sv]
// ----------------------------------------------------------------------------
// mcad_req_if
// request channel: alarm reports and tick items
// ----------------------------------------------------------------------------
interface mcad_req_if import mcad_pkg::*; ();
  logic      valid;
  logic      ready;
  req_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/mcad_rsp_if.sv]
// ----------------------------------------------------------------------------
// mcad_rsp_if
// result channel: confirmed changes with their edge events
// ----------------------------------------------------------------------------
interface mcad_rsp_if import mcad_pkg::*; ();
  logic      valid;
  logic      ready;
  rsp_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/mcad_ctrl.sv]
// ----------------------------------------------------------------------------
// mcad_ctrl
// sequencer for report handling, tick walk and final result flush
// ----------------------------------------------------------------------------
module mcad_ctrl import mcad_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = st.is_tick ? ST_WALK : ST_REPORT;
        end
      end
      ST_REPORT: begin
        state_next = ST_FLUSH;
      end
      ST_WALK: begin
        if (!st.stall && st.walk_end) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!st.held_valid || st.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready     = 1'b0;
    cmd           = '0;
    unique case (state)
      ST_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
      end
      ST_REPORT: cmd.rpt_eval  = 1'b1;
      ST_WALK:   cmd.walk_eval = 1'b1;
      ST_FLUSH:  cmd.flush     = 1'b1;
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

endmodule

[hw/rtl/mcad_datapath.sv]
// ----------------------------------------------------------------------------
// mcad_datapath
// channel state memory, debounce evaluation, held result and output register
// ----------------------------------------------------------------------------
module mcad_datapath import mcad_pkg::*; #(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
  parameter int COUNT_BITS   = DEF_COUNT_BITS
) (
  input  logic       clk,
  input  logic       rst,
  input  req_item_t  req_data,
  input  dp_cmd_t    cmd,
  output dp_status_t st,
  mcad_rsp_if.source rsp
);

  localparam int CH_BITS = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int NE_BITS = $clog2(MAX_RESULTS + 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic [2:0]            conf;
    logic                  pvalid;
    logic                  pstatus;
    logic [LVL_W-1:0]      plevel;
    logic [COUNT_BITS-1:0] pcount;
    logic                  seen;
    logic                  latched;
  } chan_word_t;

  chan_word_t mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] init_ok;
  chan_word_t rd_q;
  logic       rd_ok;
  chan_word_t ent;

  req_item_t         cap;
  logic [CH_BITS-1:0] walk_ch;
  logic [NE_BITS-1:0] n_emit;
  logic              held_valid;
  rsp_item_t         held;
  rsp_item_t         held_last;
  logic              out_valid;
  rsp_item_t         out_data;

  logic [CH_BITS-1:0]    rd_addr;
  logic [CH_BITS-1:0]    wr_addr;
  logic                  wr_go;
  chan_word_t            wr_data;
  logic                  walk_end;
  logic                  out_free;
  logic                  req_rng;
  logic                  rpt_ignore;
  logic [1:0]            r_idx;
  logic [3:0]            r_conf_ext;
  logic                  r_cur;
  logic [COUNT_BITS-1:0] dly_sat;
  logic [COUNT_BITS-1:0] cnt_dec;
  chan_word_t            dw;
  chan_word_t            cw;
  logic [3:0]            c_conf_ext;
  logic [LVL_W-1:0]      c_lvl;
  logic                  c_st;
  event_kind_t           c_kind;
  logic                  conf_req;
  logic                  conf_go;
  logic                  stall;
  logic                  flush_go;

  assign ent      = rd_ok ? rd_q : '0;
  assign walk_end = (walk_ch == CH_BITS'(NUM_CHANNELS - 1));
  assign out_free = !out_valid || rsp.ready;
  assign req_rng  = (32'(req_data.channel) < 32'(NUM_CHANNELS));
  assign rpt_ignore = (cap.level == LVL_UNKNOWN) ||
                      (32'(cap.channel) >= 32'(NUM_CHANNELS));
  assign r_idx      = 2'(cap.level - 2'd1);
  assign r_conf_ext = {1'b0, ent.conf};
  assign r_cur      = r_conf_ext[r_idx];
  assign dly_sat    = (33'(cap.debounce_ticks) > 33'(CNT_MAX)) ?
                      CNT_MAX : COUNT_BITS'(cap.debounce_ticks);
  assign cnt_dec    = (ent.pcount != '0) ? ent.pcount - 1'b1 : '0;
  assign wr_addr    = cmd.rpt_eval ? CH_BITS'(cap.channel) : walk_ch;

  // entry with its pending change dropped
  always_comb begin
    dw         = ent;
    dw.pvalid  = 1'b0;
    dw.pstatus = 1'b0;
    dw.plevel  = '0;
    dw.pcount  = '0;
  end

  // confirmation of (c_lvl, c_st) on the current entry
  always_comb begin
    c_lvl      = cmd.rpt_eval ? cap.level : ent.plevel;
    c_st       = cmd.rpt_eval ? cap.status : ent.pstatus;
    cw         = dw;
    c_conf_ext = {1'b0, dw.conf};
    c_conf_ext[2'(c_lvl - 2'd1)] = c_st;
    cw.conf    = c_conf_ext[2:0];
    c_kind     = EV_NONE;
    if (!dw.seen) begin
      cw.seen    = 1'b1;
      cw.latched = c_st;
      c_kind     = c_st ? EV_FIRST : EV_NONE;
    end else if (c_st && !dw.latched) begin
      cw.latched = 1'b1;
      c_kind     = EV_TRIGGER;
    end else if (!c_st && dw.latched) begin
      cw.latched = 1'b0;
      c_kind     = EV_RECOVER;
    end
  end

  always_comb begin
    wr_go    = 1'b0;
    wr_data  = ent;
    conf_req = 1'b0;
    if (cmd.rpt_eval && !rpt_ignore) begin
      if (cap.status == r_cur) begin
        wr_go   = 1'b1;
        wr_data = dw;
      end else if (cap.debounce_ticks == '0) begin
        conf_req = 1'b1;
      end else if (ent.pvalid && (ent.pstatus == cap.status)) begin
        wr_go = 1'b0;
      end else begin
        wr_go           = 1'b1;
        wr_data.pvalid  = 1'b1;
        wr_data.pstatus = cap.status;
        wr_data.plevel  = cap.level;
        wr_data.pcount  = dly_sat;
      end
    end else if (cmd.walk_eval && ent.pvalid) begin
      if ((cnt_dec == '0) && (n_emit < NE_BITS'(MAX_RESULTS))) begin
        if (ent.plevel == LVL_UNKNOWN) begin
          wr_go   = 1'b1;
          wr_data = dw;
        end else begin
          conf_req = 1'b1;
        end
      end else begin
        wr_go          = 1'b1;
        wr_data.pcount = cnt_dec;
      end
    end
    // a new result needs the held slot; the held one moves to the output
    stall   = conf_req && held_valid && !out_free;
    conf_go = conf_req && !stall;
    if (conf_go) begin
      wr_go   = 1'b1;
      wr_data = cw;
    end
  end

  assign flush_go = cmd.flush && held_valid && out_free;

  // held result marked as the final one of its request
  always_comb begin
    held_last      = held;
    held_last.last = 1'b1;
  end

  always_comb begin
    if (cmd.walk_eval) begin
      if (stall) begin
        rd_addr = walk_ch;
      end else if (walk_end) begin
        rd_addr = '0;
      end else begin
        rd_addr = CH_BITS'(walk_ch + 1'b1);
      end
    end else if ((req_data.req_type == REQ_TICK) || !req_rng) begin
      rd_addr = '0;
    end else begin
      rd_addr = CH_BITS'(req_data.channel);
    end
  end

  // state memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_go) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap <= req_data;
    end
    if (conf_go) begin
      held <= '{out_channel: (cmd.rpt_eval ? cap.channel : CH_W'(walk_ch)),
                out_level:   c_lvl,
                out_status:  c_st,
                event_kind:  c_kind,
                last:        1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_ok    <= '0;
      rd_ok      <= 1'b0;
      walk_ch    <= '0;
      n_emit     <= '0;
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_ok <= init_ok[rd_addr];
      if (wr_go) begin
        init_ok[wr_addr] <= 1'b1;
      end
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (conf_go) begin
        held_valid <= 1'b1;
        n_emit     <= n_emit + 1'b1;
        if (held_valid) begin
          out_valid <= 1'b1;
          out_data  <= held;
        end
      end
      if (flush_go) begin
        out_valid  <= 1'b1;
        out_data   <= held_last;
        held_valid <= 1'b0;
      end
      if (cmd.capture) begin
        walk_ch <= '0;
        n_emit  <= '0;
      end else if (cmd.walk_eval && !stall && !walk_end) begin
        walk_ch <= CH_BITS'(walk_ch + 1'b1);
      end
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  assign st.is_tick    = (req_data.req_type == REQ_TICK);
  assign st.stall      = stall;
  assign st.walk_end   = walk_end;
  assign st.held_valid = held_valid;
  assign st.out_free   = out_free;

endmodule

[hw/rtl/multi_channel_alarm_debouncer_top.sv]
// ----------------------------------------------------------------------------
// multi_channel_alarm_debouncer_top
// per-channel debounce of multi-level alarm reports with edge events
// ----------------------------------------------------------------------------
//  channel  | role   | payload
//  ---------+--------+-------------------------------------------------------
//  req      | sink   | req_type, channel, level, status, debounce_ticks
//  rsp      | source | out_channel, out_level, out_status, event_kind, last
//
// report: capture with state read, evaluate and write back, then flush
// tick: one channel per cycle through the single read port while the walk is not held
// a confirmation that finds the held slot and the output register both full holds
// the walk in place, and the flush waits for a free output register
// rst is synchronous; per-channel valid bits make the state read as zero after reset
// the next request is taken once the final result sits in the output register
`include "multi_channel_alarm_debouncer_top_defines.svh"

module multi_channel_alarm_debouncer_top import mcad_pkg::*; #(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
  parameter int COUNT_BITS   = DEF_COUNT_BITS
) (
  input  logic       clk,
  input  logic       rst,
  mcad_req_if.sink   req,
  mcad_rsp_if.source rsp
);

  // command and status between sequencer and datapath
  dp_cmd_t    cmd;
  dp_status_t st;

  // sequencer: idle, report evaluate, tick walk, flush of the final result
  mcad_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // datapath: channel state memory, decision logic, held result and
  // output register; one result is held back so last can be set on it
  mcad_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .req_data (req.data),
    .cmd      (cmd),
    .st       (st),
    .rsp      (rsp)
  );

  // a new request never finds a result still held back
  `MCAD_ASSERT_NOW(a_accept_held_empty, req.valid && req.ready, !st.held_valid,
    "request accepted while a result is still held")

  // a result without last is always followed by a held one
  `MCAD_ASSERT_NOW(a_not_last_has_next, rsp.valid && !rsp.data.last, st.held_valid,
    "non-final result with nothing behind it")

  // the walk ends right after its final channel
  `MCAD_ASSERT_NEXT(a_walk_ends, cmd.walk_eval && !st.stall && st.walk_end,
    !cmd.walk_eval, "tick walk ran past the last channel")

endmodule
